/* rtl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and helper functions for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef logic [15:0][31:0] md5_block_t;
    typedef logic [3:0][31:0]  md5_words4_t;

    typedef struct packed {
        logic start;   // load working words from chain, run 64 rounds
        logic init;    // chain back to the initial values
    } md5_core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;    // fold into chain happens at this edge
    } md5_core_stat_t;

    localparam md5_words4_t MD5_IV = {32'h10325476, 32'h98badcfe,
                                      32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'h3f;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] round);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = round[3:0];
        unique case (round[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(5 * i4 + 1);
            2'd2:    g = 4'(3 * i4 + 5);
            default: g = 4'(7 * i4);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* rtl/md5_round.sv */
// ----------------------------------------------------------------------------
// md5_round
// Shared MD5 round datapath: the four-operand sum of one round and the
// rotate-and-add that produces the new b word.
// ----------------------------------------------------------------------------
module md5_round (
    input  logic [5:0]  round,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    input  logic [31:0] t,      // registered sum from the previous half-step
    output logic [31:0] sum,
    output logic [31:0] new_b
);

    logic [31:0] f;
    logic [4:0]  shamt;

    always_comb
    begin
        unique case (round[5:4])
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
    end

    assign sum   = a + f + m + md5_pkg::K_TABLE[round];
    assign shamt = md5_pkg::ROT_TABLE[{round[5:4], round[1:0]}];
    assign new_b = b + md5_pkg::rotl32(t, shamt);

endmodule

/* rtl/md5_core.sv */
// ----------------------------------------------------------------------------
// md5_core
// Compression sequencer: holds the chaining words, runs 64 rounds through
// the shared round unit (sum step, rotate step), then folds into the chain.
// ----------------------------------------------------------------------------
module md5_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  md5_pkg::md5_core_ctrl_t ctrl,
    input  md5_pkg::md5_block_t     block,
    output md5_pkg::md5_core_stat_t stat,
    output md5_pkg::md5_words4_t    chain
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SUM  = 2'd1;
    localparam logic [1:0] PH_ROT  = 2'd2;
    localparam logic [1:0] PH_FOLD = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, t_reg;
    md5_pkg::md5_words4_t chain_reg, chain_next;

    logic [31:0] m_word;
    logic [31:0] sum;
    logic [31:0] new_b;

    assign m_word = block[md5_pkg::msg_index(round_reg)];

    md5_round u_round (
        .round (round_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (m_word),
        .t     (t_reg),
        .sum   (sum),
        .new_b (new_b)
    );

    always_comb
    begin
        phase_next = phase_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (ctrl.start)
                begin
                    phase_next = PH_SUM;
                    round_next = '0;
                end
            end
            PH_SUM:
            begin
                phase_next = PH_ROT;
            end
            PH_ROT:
            begin
                if (round_reg == md5_pkg::LAST_ROUND)
                begin
                    phase_next = PH_FOLD;
                end
                else
                begin
                    phase_next = PH_SUM;
                    round_next = round_reg + 6'd1;
                end
            end
            PH_FOLD:
            begin
                phase_next    = PH_IDLE;
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (ctrl.init)
        begin
            chain_next = md5_pkg::MD5_IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            round_reg <= '0;
            chain_reg <= md5_pkg::MD5_IV;
        end
        else
        begin
            phase_reg <= phase_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    // working words: no reset needed
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && ctrl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (phase_reg == PH_SUM)
        begin
            t_reg <= sum;
        end
        else if (phase_reg == PH_ROT)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= new_b;
        end
    end

    assign stat.busy = (phase_reg != PH_IDLE);
    assign stat.done = (phase_reg == PH_FOLD);
    assign chain     = chain_reg;

endmodule

/* rtl/md5_stream_hash.sv */
// ----------------------------------------------------------------------------
// md5_stream_hash
// MD5 digest of a byte stream, one optional byte per input transaction.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts a compression: the single round unit runs
// each of the 64 rounds as a sum step and a rotate step, then folds into
// the chain, with tready held low throughout. An end-of-message transaction
// adds a padding step and one compression, or two compressions with a
// length-clearing step between them when fewer than 9 bytes of the block
// remain, then loads the digest into the output register (later while an
// earlier digest still waits there). Input is taken again while that digest
// waits.
module md5_stream_hash (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] digest_first_half,
                                         // [127:64] digest_second_half
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  after_reg, after_next;   // where to go once compression ends
    logic [63:0] bit_count_reg, bit_count_next;
    md5_pkg::md5_block_t block_reg, block_next;
    logic        out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg;

    md5_pkg::md5_core_ctrl_t core_ctrl;
    md5_pkg::md5_core_stat_t core_stat;
    md5_pkg::md5_words4_t    chain;

    logic       in_accept;
    logic       out_free;
    logic       out_load;
    logic [5:0] pos;
    logic [3:0] word_idx;
    logic [1:0] lane_idx;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pos           = bit_count_reg[8:3];
    assign word_idx      = pos[5:2];
    assign lane_idx      = pos[1:0];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && out_free;

    md5_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .block (block_reg),
        .stat  (core_stat),
        .chain (chain)
    );

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        bit_count_next = bit_count_reg;
        block_next     = block_reg;
        core_ctrl      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser)
                    begin
                        block_next[word_idx][{lane_idx, 3'b000} +: 8] = s_axis_tdata;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (s_axis_tuser && pos == md5_pkg::LAST_POS)
                    begin
                        core_ctrl.start = 1'b1;
                        state_next      = ST_COMP;
                        after_next      = s_axis_tlast ? ST_PAD : ST_IDLE;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // 0x80 at the current byte, zeros above it
                for (int j = 0; j < 16; j++)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (4'(j) > word_idx)
                        begin
                            block_next[j][8*l +: 8] = '0;
                        end
                        else if (4'(j) == word_idx)
                        begin
                            if (2'(l) > lane_idx)
                            begin
                                block_next[j][8*l +: 8] = '0;
                            end
                            else if (2'(l) == lane_idx)
                            begin
                                block_next[j][8*l +: 8] = md5_pkg::PAD_BYTE;
                            end
                        end
                    end
                end
                core_ctrl.start = 1'b1;
                state_next      = ST_COMP;
                if (pos >= md5_pkg::LEN_POS)
                begin
                    after_next = ST_LEN;
                end
                else
                begin
                    block_next[14] = bit_count_reg[31:0];
                    block_next[15] = bit_count_reg[63:32];
                    after_next     = ST_OUT;
                end
            end
            ST_COMP:
            begin
                if (core_stat.done)
                begin
                    state_next = after_reg;
                end
            end
            ST_LEN:
            begin
                block_next      = '0;
                block_next[14]  = bit_count_reg[31:0];
                block_next[15]  = bit_count_reg[63:32];
                core_ctrl.start = 1'b1;
                state_next      = ST_COMP;
                after_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    core_ctrl.init = 1'b1;
                    bit_count_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            bit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            bit_count_reg <= bit_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        if (out_load)
        begin
            out_data_reg <= {md5_pkg::swap32(chain[2]), md5_pkg::swap32(chain[3]),
                             md5_pkg::swap32(chain[0]), md5_pkg::swap32(chain[1])};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // no input taken while the round unit is working
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.busy |-> !s_axis_tready)
        else $error("input accepted during compression");

    // the core only finishes while the sequencer is waiting for it
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == ST_COMP)
        else $error("compression ended outside ST_COMP");

    // emitting a digest re-initialises the message length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (bit_count_reg == 64'd0 && m_axis_tvalid))
        else $error("state not re-initialised after digest");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md5_stream_hash. A short table of known messages
// runs first, then random messages shaped around the padding boundaries.
// Each accepted transaction updates a local MD5 model; digests are queued
// and compared half by half with the output stream, under random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 1700;
    localparam int MIN_DIGESTS  = 20;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [7:0]   data_byte;
        logic         has_byte;
        logic         end_msg;
        logic         known;      // digest typed in below
        logic [127:0] digest;     // [63:0] first half, [127:64] second half
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    // local copy of the hasher state
    logic [31:0]  hash_chain [4];
    logic [31:0]  msg_words [16];
    logic [63:0]  msg_bits;

    logic [127:0] pending_digests [$];
    stim_row_t    known_rows [$];

    int           fails;
    int           cycle_count;
    int           data_items;
    int           digests_queued;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         hold_req;
    logic         hold_done;

    md5_stream_hash u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    task automatic clear_hash();
        hash_chain[0] = IV_A;
        hash_chain[1] = IV_B;
        hash_chain[2] = IV_C;
        hash_chain[3] = IV_D;
        for (int k = 0; k < 16; k++)
            msg_words[k] = '0;
        msg_bits = '0;
    endtask

    task automatic fold_block();
        logic [31:0] a, b, c, d, f, sum;
        int          g;
        int          sh;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = d ^ (b & (c ^ d));
                    g = i;
                end
                1:
                begin
                    f = c ^ (d & (b ^ c));
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sh  = ROUND_SHIFT[(i / 16) * 4 + (i % 4)];
            sum = a + f + msg_words[g] + ROUND_K[i];
            a   = d;
            d   = c;
            c   = b;
            b   = b + ((sum << sh) | (sum >> (32 - sh)));
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
    endtask

    // Absorbs one transaction; made is set when it closes a message.
    task automatic hash_item(input logic [7:0] data_byte, input logic has_byte,
                             input logic end_msg, output logic made,
                             output logic [127:0] digest);
        int          pos;
        int          w;
        int          lane;
        logic [31:0] keep;
        made   = 1'b0;
        digest = '0;
        if (has_byte)
        begin
            pos  = int'(msg_bits[8:3]);
            w    = pos / 4;
            lane = (pos % 4) * 8;
            msg_words[w] = (msg_words[w] & ~(32'hff << lane))
                         | ({24'd0, data_byte} << lane);
            msg_bits += 64'd8;
            if (pos == 63)
                fold_block();
        end
        if (end_msg)
        begin
            pos  = int'(msg_bits[8:3]);
            w    = pos / 4;
            lane = (pos % 4) * 8;
            keep = (32'h1 << lane) - 32'h1;
            msg_words[w] = (msg_words[w] & keep) | (32'h80 << lane);
            for (int k = w + 1; k < 16; k++)
                msg_words[k] = '0;
            // no room for the length: spill into a second block
            if (pos >= 56)
            begin
                fold_block();
                for (int k = 0; k < 16; k++)
                    msg_words[k] = '0;
            end
            msg_words[14] = msg_bits[31:0];
            msg_words[15] = msg_bits[63:32];
            fold_block();
            digest = {byte_rev(hash_chain[2]), byte_rev(hash_chain[3]),
                      byte_rev(hash_chain[0]), byte_rev(hash_chain[1])};
            made = 1'b1;
            clear_hash();
        end
    endtask

    task automatic add_row(input logic [7:0] data_byte, input logic has_byte,
                           input logic end_msg, input logic known,
                           input logic [63:0] first_half,
                           input logic [63:0] second_half);
        stim_row_t row;
        row.data_byte = data_byte;
        row.has_byte  = has_byte;
        row.end_msg   = end_msg;
        row.known     = known;
        row.digest    = {second_half, first_half};
        known_rows.push_back(row);
    endtask

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                             input logic end_msg, input logic known,
                             input logic [127:0] known_digest);
        logic         made;
        logic [127:0] digest;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data_byte;
        s_axis_tuser  = has_byte;
        s_axis_tlast  = end_msg;
        do
            @(posedge clk);
        while (!s_axis_tready);
        hash_item(data_byte, has_byte, end_msg, made, digest);
        if (made)
        begin
            pending_digests.push_back(known ? known_digest : digest);
            digests_queued++;
        end
        if (has_byte || end_msg)
            data_items++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic update_phase();
        if (data_items < ITEM_TARGET / 3)
        begin
            send_idle_pct = 23;
            recv_idle_pct = 84;
        end
        else if (data_items < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 84;
            recv_idle_pct = 23;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_req      = 1'b1;
        end
    endtask

    // lengths cluster around the points where padding needs an extra block
    function automatic int pick_length();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return $urandom_range(12);
        if (r < 7)
        begin
            case ($urandom_range(9))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 62;
                4: return 63;
                5: return 64;
                6: return 65;
                7: return 119;
                8: return 120;
                default: return 128;
            endcase
        end
        return $urandom_range(150);
    endfunction

    task automatic send_message(input int len);
        logic tail_apart;
        tail_apart = 1'($urandom_range(1));
        if (len == 0)
        begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
            return;
        end
        for (int k = 0; k < len; k++)
        begin
            // stray transactions without a byte, ignored by the block
            if ($urandom_range(99) < 8)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom_range(255)), 1'b1,
                      (k == len - 1) && !tail_apart, 1'b0, '0);
        end
        if (tail_apart)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
    endtask

    // output side: random stalls plus one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready = 1'b0;
                hold_done     = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digests.size() == 0)
            begin
                $display("%0t: unexpected digest %h", $time, m_axis_tdata);
                fails++;
            end
            else
            begin
                if (m_axis_tdata[63:0] !== pending_digests[0][63:0])
                begin
                    $display("%0t: digest first half expected %h got %h", $time,
                             pending_digests[0][63:0], m_axis_tdata[63:0]);
                    fails++;
                end
                if (m_axis_tdata[127:64] !== pending_digests[0][127:64])
                begin
                    $display("%0t: digest second half expected %h got %h", $time,
                             pending_digests[0][127:64], m_axis_tdata[127:64]);
                    fails++;
                end
                void'(pending_digests.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        fails          = 0;
        cycle_count    = 0;
        data_items     = 0;
        digests_queued = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        send_idle_pct  = 23;
        recv_idle_pct  = 84;
        clear_hash();

        // empty message
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e);
        // no byte, no end: nothing happens
        add_row(8'hff, 1'b0, 1'b0, 1'b0, '0, '0);
        // "a" closed on its own byte
        add_row(8'h61, 1'b1, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661);
        // "abc"
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, 64'h900150983cd24fb0, 64'hd6963f7d28e17f72);
        // "a" closed by a separate end without a byte; data is ignored
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'hff, 1'b0, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661);
        // byte extremes
        add_row(8'hff, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0, '0);
        add_row(8'haa, 1'b0, 1'b0, 1'b0, '0, '0);
        add_row(8'h55, 1'b1, 1'b1, 1'b0, '0, '0);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0, '0);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0, '0);
        // back-to-back empty messages
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e);
        add_row(8'hff, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (known_rows[i])
        begin
            row = known_rows[i];
            send_item(row.data_byte, row.has_byte, row.end_msg, row.known, row.digest);
        end

        while (data_items < ITEM_TARGET || digests_queued < MIN_DIGESTS)
        begin
            update_phase();
            send_message(pick_length());
        end

        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
